@@ rtl/core/cdf_pkg.sv @@
// ----------------------------------------------------------------------------
// cdf_pkg
// Types, constants and small functions shared by the calendar date pipeline.
// ----------------------------------------------------------------------------
package cdf_pkg;

  localparam int YearW  = 14;
  localparam int MonthW = 4;
  localparam int DayW   = 5;
  localparam int MlenW  = 5;
  localparam int WdayW  = 3;
  localparam int OrdW   = 9;
  localparam int WeekW  = 6;

  // Shifted years are at most 16383 + 400, which needs 15 bits.
  localparam int ZyW   = 15;
  localparam int CentW = 8;
  localparam int RemW  = 7;

  // x / 100 == (x * 5243) >> 19 for every x below 43690.
  localparam int unsigned Div100Mul   = 5243;
  localparam int          Div100Shift = 19;
  // x / 7 == (x * 293) >> 11 for every x below 683.
  localparam int unsigned Div7Mul     = 293;
  localparam int          Div7Shift   = 11;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthMar = 4'd3;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;
  localparam logic [MonthW-1:0] ZellerJan = 4'd13;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [CentW-1:0]  yq;     // year / 100
    logic [MonthW-1:0] zm;     // Zeller month of the date (3..15)
    logic [ZyW-1:0]    zy;     // Zeller year of the date, 400 years on
    logic [CentW-1:0]  zq;     // zy / 100
    logic [ZyW-1:0]    jy;     // Zeller year of January 1
    logic [CentW-1:0]  jq;     // jy / 100
  } s1_t;

  typedef struct packed {
    logic              leap;
    logic [MlenW-1:0]  mlen;
    logic [OrdW-1:0]   ord;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] zm;
    logic [RemW-1:0]   zk;
    logic [CentW-1:0]  zj;
    logic [RemW-1:0]   jk;
    logic [CentW-1:0]  jj;
  } s2_t;

  typedef struct packed {
    logic              leap;
    logic [MlenW-1:0]  mlen;
    logic [OrdW-1:0]   ord;
    logic [WdayW-1:0]  wday;
    logic [WdayW-1:0]  jan1;
  } s3_t;

  function automatic logic [CentW-1:0] div100(input logic [ZyW-1:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'(Div100Mul);
    return p[Div100Shift+CentW-1:Div100Shift];
  endfunction

  function automatic logic [RemW-1:0] rem100(input logic [ZyW-1:0] x,
                                              input logic [CentW-1:0] q);
    logic [ZyW-1:0] r;
    r = x - ZyW'(q * 15'd100);
    return r[RemW-1:0];
  endfunction

  // 11-bit value modulo 7 by folding octal digits (8 is 1 modulo 7).
  function automatic logic [2:0] mod7(input logic [10:0] x);
    logic [4:0] s;
    logic [3:0] t;
    s = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[10:9]);
    t = 4'(s[4:3]) + 4'(s[2:0]);
    return (t >= 4'd7) ? 3'(t - 4'd7) : t[2:0];
  endfunction

  // floor(13 * (mm + 1) / 5) for Zeller months 3..15.
  function automatic logic [5:0] zeller_month_term(input logic [MonthW-1:0] mm);
    logic [5:0] v;
    unique case (mm)
      4'd3:    v = 6'd10;
      4'd4:    v = 6'd13;
      4'd5:    v = 6'd15;
      4'd6:    v = 6'd18;
      4'd7:    v = 6'd20;
      4'd8:    v = 6'd23;
      4'd9:    v = 6'd26;
      4'd10:   v = 6'd28;
      4'd11:   v = 6'd31;
      4'd12:   v = 6'd33;
      4'd13:   v = 6'd36;
      4'd14:   v = 6'd39;
      4'd15:   v = 6'd41;
      default: v = 6'd0;
    endcase
    return v;
  endfunction

  function automatic logic [MlenW-1:0] month_len(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [MlenW-1:0] v;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    v = 5'd30;
      4'd2:    v = leap ? 5'd29 : 5'd28;
      default: v = 5'd0;
    endcase
    return v;
  endfunction

  // Days of the common-year months that lie before month m.
  function automatic logic [OrdW-1:0] days_before(input logic [MonthW-1:0] m);
    logic [OrdW-1:0] v;
    unique case (m)
      4'd0, 4'd1: v = 9'd0;
      4'd2:       v = 9'd31;
      4'd3:       v = 9'd59;
      4'd4:       v = 9'd90;
      4'd5:       v = 9'd120;
      4'd6:       v = 9'd151;
      4'd7:       v = 9'd181;
      4'd8:       v = 9'd212;
      4'd9:       v = 9'd243;
      4'd10:      v = 9'd273;
      4'd11:      v = 9'd304;
      4'd12:      v = 9'd334;
      default:    v = 9'd365;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/cdf_div_stage.sv @@
// ----------------------------------------------------------------------------
// cdf_div_stage
// First stage: Zeller month and year shift, and the three divisions by 100.
// ----------------------------------------------------------------------------
module cdf_div_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [cdf_pkg::YearW-1:0]  in_year,
  input  logic [cdf_pkg::MonthW-1:0] in_month,
  input  logic [cdf_pkg::DayW-1:0]   in_day,
  output logic                       s1_valid,
  output cdf_pkg::s1_t               s1
);

  logic         valid_r;
  cdf_pkg::s1_t data_r;
  cdf_pkg::s1_t data_nxt;

  always_comb begin
    data_nxt       = '0;
    data_nxt.year  = in_year;
    data_nxt.month = in_month;
    data_nxt.day   = in_day;
    data_nxt.yq    = cdf_pkg::div100(cdf_pkg::ZyW'(in_year));
    // January and February count as months 13 and 14 of the year before.
    if (in_month < cdf_pkg::MonthMar) begin
      data_nxt.zm = in_month + cdf_pkg::MonthDec;
      data_nxt.zy = cdf_pkg::ZyW'(in_year) + 15'd399;
    end else begin
      data_nxt.zm = in_month;
      data_nxt.zy = cdf_pkg::ZyW'(in_year) + 15'd400;
    end
    data_nxt.zq = cdf_pkg::div100(data_nxt.zy);
    data_nxt.jy = cdf_pkg::ZyW'(in_year) + 15'd399;
    data_nxt.jq = cdf_pkg::div100(data_nxt.jy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign s1_valid = valid_r;
  assign s1       = data_r;

endmodule

@@ rtl/core/cdf_rem_stage.sv @@
// ----------------------------------------------------------------------------
// cdf_rem_stage
// Second stage: remainders by 100, leap flag, month length and ordinal day.
// ----------------------------------------------------------------------------
module cdf_rem_stage (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         s1_valid,
  input  cdf_pkg::s1_t s1,
  output logic         s2_valid,
  output cdf_pkg::s2_t s2
);

  logic                      valid_r;
  cdf_pkg::s2_t              data_r;
  cdf_pkg::s2_t              data_nxt;
  logic [cdf_pkg::RemW-1:0]  yk;

  always_comb begin
    data_nxt = '0;
    yk       = cdf_pkg::rem100(cdf_pkg::ZyW'(s1.year), s1.yq);
    // A century year is a leap year only when the century divides by four.
    data_nxt.leap = (s1.year[1:0] == 2'd0) && ((yk != '0) || (s1.yq[1:0] == 2'd0));
    data_nxt.mlen = cdf_pkg::month_len(s1.month, data_nxt.leap);
    data_nxt.ord  = cdf_pkg::days_before(s1.month)
                  + cdf_pkg::OrdW'(data_nxt.leap && (s1.month >= cdf_pkg::MonthMar))
                  + cdf_pkg::OrdW'(s1.day);
    data_nxt.day  = s1.day;
    data_nxt.zm   = s1.zm;
    data_nxt.zk   = cdf_pkg::rem100(s1.zy, s1.zq);
    data_nxt.zj   = s1.zq;
    data_nxt.jk   = cdf_pkg::rem100(s1.jy, s1.jq);
    data_nxt.jj   = s1.jq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign s2_valid = valid_r;
  assign s2       = data_r;

endmodule

@@ rtl/core/cdf_zeller_stage.sv @@
// ----------------------------------------------------------------------------
// cdf_zeller_stage
// Third stage: Zeller's congruence for the date and for January 1.
// ----------------------------------------------------------------------------
module cdf_zeller_stage (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         s2_valid,
  input  cdf_pkg::s2_t s2,
  output logic         s3_valid,
  output cdf_pkg::s3_t s3
);

  logic         valid_r;
  cdf_pkg::s3_t data_r;
  cdf_pkg::s3_t data_nxt;
  logic [10:0]  zsum;
  logic [10:0]  jsum;
  logic [2:0]   zh;
  logic [2:0]   jh;

  // The factor 5 on the century stands for -2 modulo 7.
  always_comb begin
    zsum = 11'(s2.day) + 11'(cdf_pkg::zeller_month_term(s2.zm)) + 11'(s2.zk)
         + 11'(s2.zk[6:2]) + 11'(s2.zj[7:2]) + 11'(s2.zj) * 11'd5;
    jsum = 11'd1 + 11'(cdf_pkg::zeller_month_term(cdf_pkg::ZellerJan)) + 11'(s2.jk)
         + 11'(s2.jk[6:2]) + 11'(s2.jj[7:2]) + 11'(s2.jj) * 11'd5;
    zh   = cdf_pkg::mod7(zsum);
    jh   = cdf_pkg::mod7(jsum);

    data_nxt      = '0;
    data_nxt.leap = s2.leap;
    data_nxt.mlen = s2.mlen;
    data_nxt.ord  = s2.ord;
    // Zeller counts from Saturday; move the origin to Sunday.
    data_nxt.wday = (zh == 3'd0) ? 3'd6 : zh - 3'd1;
    data_nxt.jan1 = (jh == 3'd0) ? 3'd6 : jh - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign s3_valid = valid_r;
  assign s3       = data_r;

endmodule

@@ rtl/core/cdf_week_stage.sv @@
// ----------------------------------------------------------------------------
// cdf_week_stage
// Last stage: week number and the result registers.
// ----------------------------------------------------------------------------
module cdf_week_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      s3_valid,
  input  cdf_pkg::s3_t              s3,
  output logic                      out_valid,
  output logic                      out_leap_year,
  output logic [cdf_pkg::MlenW-1:0] out_month_length,
  output logic [cdf_pkg::WdayW-1:0] out_weekday,
  output logic [cdf_pkg::OrdW-1:0]  out_ordinal_day,
  output logic [cdf_pkg::WeekW-1:0] out_week_number
);

  logic                      valid_r;
  logic                      leap_r;
  logic [cdf_pkg::MlenW-1:0] mlen_r;
  logic [cdf_pkg::WdayW-1:0] wday_r;
  logic [cdf_pkg::OrdW-1:0]  ord_r;
  logic [cdf_pkg::WeekW-1:0] week_r;
  logic [cdf_pkg::WeekW-1:0] week_nxt;
  logic [9:0]                sum;
  logic [9:0]                days;
  logic [19:0]               prod;
  logic [cdf_pkg::WeekW-1:0] q7;

  always_comb begin
    sum  = 10'(s3.ord) + 10'(s3.jan1);
    days = (sum == '0) ? '0 : sum - 10'd1;
    prod = 20'(days) * 20'(cdf_pkg::Div7Mul);
    q7   = prod[cdf_pkg::Div7Shift+cdf_pkg::WeekW-1:cdf_pkg::Div7Shift];
    // A year whose January 1 falls Sunday to Thursday starts in week one.
    week_nxt = q7 + cdf_pkg::WeekW'(s3.jan1 <= 3'd4);
    if (week_nxt == '0) begin
      week_nxt = 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    leap_r <= s3.leap;
    mlen_r <= s3.mlen;
    wday_r <= s3.wday;
    ord_r  <= s3.ord;
    week_r <= week_nxt;
  end

  assign out_valid        = valid_r;
  assign out_leap_year    = leap_r;
  assign out_month_length = mlen_r;
  assign out_weekday      = wday_r;
  assign out_ordinal_day  = ord_r;
  assign out_week_number  = week_r;

endmodule

@@ rtl/core/calendar_date_facts_unit.sv @@
// ----------------------------------------------------------------------------
// calendar_date_facts_unit
// Leap flag, month length, weekday, ordinal day and week number of a date.
// ----------------------------------------------------------------------------
//   channel   handshake            payload
//   request   start / busy         in_year, in_month, in_day
//   result    out_valid (strobe)   out_leap_year, out_month_length, out_weekday,
//                                  out_ordinal_day, out_week_number
//
// A request is taken in every cycle in which busy is low; its result is strobed
// one per request, in order, after it passes the four pipeline stages:
// divisions by 100, remainders and day counts, Zeller sums, week division.
// Reset clears the stage valid bits; busy is high only while reset is held.
// The receiver cannot stall, so nothing in the pipeline ever waits.
// ----------------------------------------------------------------------------
module calendar_date_facts_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [cdf_pkg::YearW-1:0]  in_year,
  input  logic [cdf_pkg::MonthW-1:0] in_month,
  input  logic [cdf_pkg::DayW-1:0]   in_day,
  output logic                       out_valid,
  output logic                       out_leap_year,
  output logic [cdf_pkg::MlenW-1:0]  out_month_length,
  output logic [cdf_pkg::WdayW-1:0]  out_weekday,
  output logic [cdf_pkg::OrdW-1:0]   out_ordinal_day,
  output logic [cdf_pkg::WeekW-1:0]  out_week_number
);

  logic         req_valid;
  logic         s1_valid;
  logic         s2_valid;
  logic         s3_valid;
  cdf_pkg::s1_t s1;
  cdf_pkg::s2_t s2;
  cdf_pkg::s3_t s3;

  assign busy      = !rst_n;
  assign req_valid = start && !busy;

  cdf_div_stage u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (req_valid),
    .in_year  (in_year),
    .in_month (in_month),
    .in_day   (in_day),
    .s1_valid (s1_valid),
    .s1       (s1)
  );

  cdf_rem_stage u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s2_valid (s2_valid),
    .s2       (s2)
  );

  cdf_zeller_stage u_zeller (
    .clk      (clk),
    .rst_n    (rst_n),
    .s2_valid (s2_valid),
    .s2       (s2),
    .s3_valid (s3_valid),
    .s3       (s3)
  );

  cdf_week_stage u_week (
    .clk              (clk),
    .rst_n            (rst_n),
    .s3_valid         (s3_valid),
    .s3               (s3),
    .out_valid        (out_valid),
    .out_leap_year    (out_leap_year),
    .out_month_length (out_month_length),
    .out_weekday      (out_weekday),
    .out_ordinal_day  (out_ordinal_day),
    .out_week_number  (out_week_number)
  );

  // Every request that is taken comes out as a result strobe.
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    req_valid |-> ##4 out_valid)
    else $error("result strobe missing four cycles after a request");

  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(s3_valid))
    else $error("result strobe without an item in the last stage");

  a_leap_feb : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_month_length == 5'd29) |-> out_leap_year)
    else $error("29-day month reported in a common year");

  a_ranges : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_weekday <= 3'd6) && (out_week_number != 6'd0))
    else $error("weekday or week number out of range");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Calendar date facts unit testbench
// Sends dates in random bursts and checks every strobed result against a
// behavioral model of the Gregorian calendar.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct {
    logic [cdf_pkg::YearW-1:0]  year;
    logic [cdf_pkg::MonthW-1:0] month;
    logic [cdf_pkg::DayW-1:0]   day;
    logic                       leap;
    logic [cdf_pkg::MlenW-1:0]  mlen;
    logic [cdf_pkg::WdayW-1:0]  wday;
    logic [cdf_pkg::OrdW-1:0]   ord;
    logic [cdf_pkg::WeekW-1:0]  week;
  } date_facts_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic [cdf_pkg::YearW-1:0]  in_year = '0;
  logic [cdf_pkg::MonthW-1:0] in_month = '0;
  logic [cdf_pkg::DayW-1:0]   in_day = '0;
  logic                       busy;
  logic                       out_valid;
  logic                       out_leap_year;
  logic [cdf_pkg::MlenW-1:0]  out_month_length;
  logic [cdf_pkg::WdayW-1:0]  out_weekday;
  logic [cdf_pkg::OrdW-1:0]   out_ordinal_day;
  logic [cdf_pkg::WeekW-1:0]  out_week_number;

  logic busy_at_fall = 1'b1;
  logic start_next = 1'b0;

  date_facts_t pending_facts[$];
  int          burst_left = 1;
  int          requests_sent = 0;
  int          odd_requests = 0;
  int          results_checked = 0;
  int          mismatch_count = 0;
  int          error_count = 0;

  calendar_date_facts_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_year          (in_year),
    .in_month         (in_month),
    .in_day           (in_day),
    .out_valid        (out_valid),
    .out_leap_year    (out_leap_year),
    .out_month_length (out_month_length),
    .out_weekday      (out_weekday),
    .out_ordinal_day  (out_ordinal_day),
    .out_week_number  (out_week_number)
  );

  always #5 clk = ~clk;

  // Busy only changes at a rising edge, so its value at the falling edge is
  // the one the block sees at the next rising edge.
  always @(negedge clk) begin
    busy_at_fall = busy;
  end

  function automatic bit year_is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return year_is_leap(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Zeller's congruence four centuries on, so that no term goes negative;
  // the result is remapped so that Sunday is zero.
  function automatic int unsigned zeller_weekday(input int unsigned y, input int unsigned m,
                                                 input int unsigned d);
    int unsigned yy;
    int unsigned mm;
    int unsigned k;
    int unsigned c;
    int unsigned h;
    yy = y + 400;
    mm = m;
    if (mm < 3) begin
      mm = mm + 12;
      yy = yy - 1;
    end
    k = yy % 100;
    c = yy / 100;
    h = (d + (13 * (mm + 1)) / 5 + k + k / 4 + c / 4 + 5 * c) % 7;
    return (h + 6) % 7;
  endfunction

  function automatic date_facts_t facts_of_date(input logic [cdf_pkg::YearW-1:0] year,
                                                input logic [cdf_pkg::MonthW-1:0] month,
                                                input logic [cdf_pkg::DayW-1:0] day);
    date_facts_t f;
    int unsigned ordinal;
    int unsigned jan1;
    int unsigned week;
    ordinal = day;
    for (int unsigned i = 1; i < month; i++) begin
      ordinal += month_days(year, i);
    end
    jan1 = zeller_weekday(year, 1, 1);
    week = (ordinal + jan1 >= 1) ? (ordinal + jan1 - 1) / 7 : 0;
    if (jan1 <= 4) begin
      week++;
    end
    if (week < 1) begin
      week = 1;
    end
    f.year  = year;
    f.month = month;
    f.day   = day;
    f.leap  = year_is_leap(year);
    f.mlen  = cdf_pkg::MlenW'(month_days(year, month));
    f.wday  = cdf_pkg::WdayW'(zeller_weekday(year, month, day));
    f.ord   = cdf_pkg::OrdW'(ordinal);
    f.week  = cdf_pkg::WeekW'(week);
    return f;
  endfunction

  // Request acceptance and result checking share one edge-triggered process.
  always @(posedge clk) begin
    date_facts_t want;
    if (rst_n && out_valid !== 1'b0) begin
      results_checked++;
      if (pending_facts.size() == 0) begin
        error_count++;
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("[%0t] result with no request outstanding", $realtime);
        end
      end else begin
        want = pending_facts.pop_front();
        if (out_leap_year !== want.leap || out_month_length !== want.mlen ||
            out_weekday !== want.wday || out_ordinal_day !== want.ord ||
            out_week_number !== want.week) begin
          error_count++;
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("[%0t] date %0d-%0d-%0d: expected leap=%0d len=%0d wday=%0d ord=%0d week=%0d",
                     $realtime, want.year, want.month, want.day, want.leap, want.mlen,
                     want.wday, want.ord, want.week);
            $display("    got leap=%0d len=%0d wday=%0d ord=%0d week=%0d",
                     out_leap_year, out_month_length, out_weekday, out_ordinal_day,
                     out_week_number);
          end
        end
      end
    end
    if (rst_n && start && !busy_at_fall) begin
      pending_facts.push_back(facts_of_date(in_year, in_month, in_day));
    end
  end

  task automatic send_date(input int unsigned y, input int unsigned m, input int unsigned d);
    int gap;
    in_year  <= cdf_pkg::YearW'(y);
    in_month <= cdf_pkg::MonthW'(m);
    in_day   <= cdf_pkg::DayW'(d);
    start    <= 1'b1;
    start_next = 1'b1;
    do begin
      @(posedge clk);
    end while (busy_at_fall);
    requests_sent++;
    if (m < 1 || m > 12 || d < 1 || d > month_days(y, m)) begin
      odd_requests++;
    end
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        start <= 1'b0;
        start_next = 1'b0;
        repeat (gap) @(posedge clk);
      end
      // Now and then a long burst keeps the request side busy every cycle.
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
  endtask

  task automatic test_directed_dates();
    send_date(1, 1, 1);
    send_date(9999, 12, 31);
    send_date(0, 1, 1);           // year zero counts as a leap year
    send_date(16383, 15, 31);     // every field at its all-ones value
    send_date(2000, 2, 29);
    send_date(1900, 2, 28);
    send_date(2024, 2, 29);
    send_date(2023, 2, 15);
    send_date(2024, 3, 15);
    send_date(2024, 0, 5);
    send_date(2024, 13, 1);
    send_date(2020, 14, 31);
    send_date(2023, 4, 31);
    send_date(2023, 6, 0);
    send_date(2023, 1, 0);        // January 1 is a Sunday, so the week sum is zero
    send_date(2023, 0, 0);
    send_date(2016, 12, 31);
    send_date(2004, 12, 31);
    send_date(2004, 15, 31);      // largest possible week number
    send_date(2012, 12, 31);
    send_date(8192, 7, 4);
    send_date(400, 3, 1);
    send_date(1, 2, 29);
  endtask

  task automatic test_valid_dates(input int count);
    int unsigned y;
    int unsigned m;
    repeat (count) begin
      case ($urandom_range(0, 3))
        0:       y = $urandom_range(1, 60) * 100 + $urandom_range(0, 1) * 4000;
        1:       y = $urandom_range(1, 40);
        default: y = $urandom_range(1, 9999);
      endcase
      m = $urandom_range(1, 12);
      send_date(y, m, $urandom_range(1, month_days(y, m)));
    end
  endtask

  task automatic test_year_edges(input int count);
    int unsigned y;
    repeat (count) begin
      y = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 99) * 100 : $urandom_range(1, 9999);
      case ($urandom_range(0, 4))
        0:       send_date(y, 1, 1);
        1:       send_date(y, 12, 31);
        2:       send_date(y, 2, month_days(y, 2));
        3:       send_date(y, 3, 1);
        default: send_date(y, 1, $urandom_range(1, 7));
      endcase
    end
  endtask

  task automatic test_raw_fields(input int count);
    repeat (count) begin
      send_date($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
    end
  endtask

  initial begin
    #2ms;
    $display("** calendar_date_facts_unit: FAILED **");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_dates();
    test_valid_dates(1100);
    test_year_edges(150);
    test_raw_fields(300);
    if (start_next) begin
      start <= 1'b0;
      start_next = 1'b0;
    end
    while (pending_facts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_facts.size() != 0) begin
      error_count++;
    end
    $display("Sent %0d dates (%0d with a month or day outside the calendar), checked %0d results.",
             requests_sent, odd_requests, results_checked);
    $display("Found %0d failing results.", error_count);
    if (error_count == 0) begin
      $display("** calendar_date_facts_unit: PASSED **");
    end else begin
      $display("** calendar_date_facts_unit: FAILED **");
    end
    $finish;
  end

endmodule

@@ calendar_date_facts_unit.f @@
rtl/core/cdf_pkg.sv
rtl/core/cdf_div_stage.sv
rtl/core/cdf_rem_stage.sv
rtl/core/cdf_zeller_stage.sv
rtl/core/cdf_week_stage.sv
rtl/core/calendar_date_facts_unit.sv
verif/testbench.sv
